// File: sv/lsmi_pkg.sv
// Shared types and constants for the left-shift modular inverse block.
`default_nettype none

package lsmi_pkg;

   // Field widths fixed by the interface
   localparam int unsigned VALUE_W = 15;
   localparam int unsigned LEN_W   = 4;   // holds the bit length of a 15-bit modulus

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;    // take a new transaction, seed u, v, r, s
      logic step;    // run one shift or add/sub pass
      logic fix1;    // pick r or s, apply the sign correction
      logic fix2;    // bring r into range and write the result register
      logic fail;    // write an error result
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic bad;     // input or modulus out of range
      logic term;    // u or v met its shift bound
      logic limit;   // pass budget used up
   } sts_type;

endpackage

`default_nettype wire

// File: sv/lsmi_datapath.sv
// Datapath: inversion words, shift trackers, end fix and result register.
`default_nettype none

module lsmi_datapath #(
   parameter int unsigned WORD_WIDTH = 16
) (
   input  wire logic                           clock,
   input  wire lsmi_pkg::cmd_type              cmd,
   output lsmi_pkg::sts_type                   sts,
   input  wire logic [lsmi_pkg::VALUE_W-1:0]   modulus,
   input  wire logic [lsmi_pkg::VALUE_W-1:0]   value,
   output logic      [lsmi_pkg::VALUE_W-1:0]   inverse,
   output logic                                status
);

   localparam int unsigned W          = WORD_WIDTH;
   localparam int unsigned PASS_LIMIT = 8 * WORD_WIDTH;
   localparam int unsigned CNT_W      = $clog2(PASS_LIMIT + 1);

   logic [W-1:0]                    u_ff, u_in, v_ff, v_in;
   logic [W-1:0]                    r_ff, r_in, s_ff, s_in;
   logic [CNT_W-1:0]                cu_ff, cu_in, cv_ff, cv_in, iter_ff, iter_in;
   logic [lsmi_pkg::LEN_W-1:0]      n_ff, n_in;
   logic [W-1:0]                    lmask_ff, lmask_in;
   logic                            bad_ff, bad_in;
   logic [lsmi_pkg::VALUE_W-1:0]    inverse_ff, inverse_in;
   logic                            status_ff, status_in;

   logic [W-1:0] p_w;
   logic [W-1:0] bound_u, bound_v;
   logic         atb_u, atb_v;
   logic         red_u, red_v, do_sub;
   logic [W-1:0] u_sel, r_sel, r_fix1, r_fix2;
   logic         res_ok;

   function automatic logic redundant(input logic [W-1:0] w,
                                      input logic [lsmi_pkg::LEN_W-1:0] nn,
                                      input logic [W-1:0] lm);
      logic [W-1:0] top_sh, nxt_sh;
      logic         top, nxt;
      top_sh = w >> nn;
      nxt_sh = w >> (nn - lsmi_pkg::LEN_W'(1));
      top    = top_sh[0];
      nxt    = nxt_sh[0];
      return (!top && !nxt) || (top && nxt && ((w & lm) != '0));
   endfunction

   function automatic logic [W-1:0] half(input logic [W-1:0] x);
      return {x[W-1], x[W-1:1]};
   endfunction

   assign p_w     = W'(modulus);
   // shift past the word width yields zero, matching a bound of zero
   assign bound_u = W'(1) << cu_ff;
   assign bound_v = W'(1) << cv_ff;
   assign atb_u   = (u_ff == bound_u) || ((u_ff + bound_u) == '0);
   assign atb_v   = (v_ff == bound_v) || ((v_ff + bound_v) == '0);
   assign red_u   = redundant(u_ff, n_ff, lmask_ff);
   assign red_v   = redundant(v_ff, n_ff, lmask_ff);

   always_comb begin
      logic [W-1:0] u_top, v_top;
      u_top  = u_ff >> n_ff;
      v_top  = v_ff >> n_ff;
      do_sub = (u_top[0] == v_top[0]);
   end

   // End fix, first half: take v and s when v met its bound, fold the sign of that word
   assign u_sel = atb_v ? v_ff : u_ff;
   assign r_sel = atb_v ? s_ff : r_ff;
   always_comb begin
      if (u_sel[W-1]) begin
         r_fix1 = r_sel[W-1] ? ('0 - r_sel) : (p_w - r_sel);
      end else begin
         r_fix1 = r_sel;
      end
   end

   // End fix, second half
   assign r_fix2 = r_ff[W-1] ? (r_ff + p_w) : r_ff;
   assign res_ok = !r_fix2[W-1] && (r_fix2 < p_w);

   always_comb begin
      logic [lsmi_pkg::LEN_W-1:0] nlen;
      nlen = '0;
      for (int i = 0; i < int'(lsmi_pkg::VALUE_W); i++) begin
         if (modulus[i]) begin
            nlen = lsmi_pkg::LEN_W'(i + 1);
         end
      end

      u_in       = u_ff;
      v_in       = v_ff;
      r_in       = r_ff;
      s_in       = s_ff;
      cu_in      = cu_ff;
      cv_in      = cv_ff;
      iter_in    = iter_ff;
      n_in       = n_ff;
      lmask_in   = lmask_ff;
      bad_in     = bad_ff;
      inverse_in = inverse_ff;
      status_in  = status_ff;

      if (cmd.load) begin
         u_in     = p_w;
         v_in     = W'(value);
         r_in     = '0;
         s_in     = W'(1);
         cu_in    = '0;
         cv_in    = '0;
         iter_in  = '0;
         n_in     = nlen;
         lmask_in = (W'(1) << (nlen - lsmi_pkg::LEN_W'(1))) - W'(1);
         bad_in   = (value == '0) || (value >= modulus) || (int'(nlen) + 1 > int'(W));
      end

      if (cmd.step) begin
         iter_in = iter_ff + CNT_W'(1);
         if (red_u) begin
            if (cu_ff >= cv_ff) begin
               r_in = r_ff << 1;
            end else begin
               s_in = half(s_ff);
            end
            u_in  = u_ff << 1;
            cu_in = cu_ff + CNT_W'(1);
         end else if (red_v) begin
            if (cv_ff >= cu_ff) begin
               s_in = s_ff << 1;
            end else begin
               r_in = half(r_ff);
            end
            v_in  = v_ff << 1;
            cv_in = cv_ff + CNT_W'(1);
         end else if (cu_ff <= cv_ff) begin
            u_in = do_sub ? (u_ff - v_ff) : (u_ff + v_ff);
            r_in = do_sub ? (r_ff - s_ff) : (r_ff + s_ff);
         end else begin
            v_in = do_sub ? (v_ff - u_ff) : (v_ff + u_ff);
            s_in = do_sub ? (s_ff - r_ff) : (s_ff + r_ff);
         end
      end

      if (cmd.fix1) begin
         r_in = r_fix1;
      end

      if (cmd.fix2) begin
         inverse_in = res_ok ? lsmi_pkg::VALUE_W'(r_fix2) : '0;
         status_in  = !res_ok;
      end

      if (cmd.fail) begin
         inverse_in = '0;
         status_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      u_ff       <= u_in;
      v_ff       <= v_in;
      r_ff       <= r_in;
      s_ff       <= s_in;
      cu_ff      <= cu_in;
      cv_ff      <= cv_in;
      iter_ff    <= iter_in;
      n_ff       <= n_in;
      lmask_ff   <= lmask_in;
      bad_ff     <= bad_in;
      inverse_ff <= inverse_in;
      status_ff  <= status_in;
   end

   assign sts.bad   = bad_ff;
   assign sts.term  = atb_u || atb_v;
   assign sts.limit = (iter_ff >= CNT_W'(PASS_LIMIT));
   assign inverse   = inverse_ff;
   assign status    = status_ff;

endmodule

`default_nettype wire

// File: sv/lsmi_ctrl.sv
// Controller: sequences load, passes, end fix and the result handshake.
`default_nettype none

module lsmi_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output lsmi_pkg::cmd_type       cmd,
   input  wire lsmi_pkg::sts_type  sts
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_RUN  = 4'b0010,
      ST_FIX1 = 4'b0100,
      ST_FIX2 = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // result register can take a new transaction this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (sts.bad || (!sts.term && sts.limit)) begin
               // hold until the result register is free
               if (out_free) begin
                  cmd.fail     = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (sts.term) begin
               state_in = ST_FIX1;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_FIX1: begin
            cmd.fix1 = 1'b1;
            state_in = ST_FIX2;
         end
         ST_FIX2: begin
            if (out_free) begin
               cmd.fix2     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: sv/left_shift_modular_inverse.sv
// Top level of the left-shift modular inverse block.
//
//   channel  dir  payload
//   req_     in   tdata[14:0] value
//   rsp_     out  tdata[14:0] inverse, tuser status (1 = error)
//   csr_     in   wdata[14:0] modulus, written when csr_we is high
//
// One transaction at a time: a load cycle, then one shift or add/sub pass per
// cycle until u or v meets its shift bound, a cycle that sees the bound, then
// the end fix in ST_FIX1 and ST_FIX2; ST_FIX2 waits for a free result register.
// Bad input or modulus fails in ST_RUN, with no pass, once the output is free.
// The pass unit of the datapath sets the rate; a new request is taken as soon
// as the result is in the output register, even before it is taken.
// Synchronous reset clears control state and sets the modulus to 3.
`default_nettype none

module left_shift_modular_inverse #(
   parameter int unsigned WORD_WIDTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [14:0] value, [15] zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [14:0] inverse, [15] zero
   output logic             rsp_tuser,   // [0] status
   input  wire logic        csr_we,
   input  wire logic [14:0] csr_wdata    // [14:0] modulus
);

   lsmi_pkg::cmd_type                cmd;
   lsmi_pkg::sts_type                sts;
   logic [lsmi_pkg::VALUE_W-1:0]     modulus_ff, modulus_in;
   logic [lsmi_pkg::VALUE_W-1:0]     inverse;
   logic                             status;

   assign modulus_in = csr_we ? csr_wdata : modulus_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= lsmi_pkg::VALUE_W'(3);
      end else begin
         modulus_ff <= modulus_in;
      end
   end

   lsmi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   lsmi_datapath #(
      .WORD_WIDTH (WORD_WIDTH)
   ) u_datapath (
      .clock   (clock),
      .cmd     (cmd),
      .sts     (sts),
      .modulus (modulus_ff),
      .value   (req_tdata[14:0]),
      .inverse (inverse),
      .status  (status)
   );

   assign rsp_tdata = {1'b0, inverse};
   assign rsp_tuser = status;

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.step, cmd.fix1, cmd.fix2, cmd.fail}))
      else $error("more than one datapath command at once");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while a transaction is in progress");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("error result carries a nonzero inverse");

   a_result_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[14:0] < modulus_ff))
      else $error("valid inverse not below the modulus");

endmodule

`default_nettype wire
